@@ src/csvt_pkg.sv @@
// ----------------------------------------------------------------------------
// csvt_pkg
// shared constants and types for the csv field tokenizer
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_CELL = 2'd1;
  localparam logic [1:0] KIND_ROW  = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] cell_byte;
  } result_t;

endpackage

@@ src/csv_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// splits csv text into cell bytes, cell ends and row ends
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  text     text_valid / text_stall   op, text_byte
//  token    token_valid / token_stall kind, cell_byte
//
//  one transaction per cycle sustained while token is not stalled, text goes through the input then the result register
//  the state flags update in one step between the input and result registers
//  rst is synchronous and clears the flags and both valid registers
//  token_stall holds the result register and stalls text only when both are full
module csv_field_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic       op,
  input  logic [7:0] text_byte,
  output logic       token_valid,
  input  logic       token_stall,
  output logic [1:0] kind,
  output logic [7:0] cell_byte
);

  csvt_pkg::item_t   item_in;
  csvt_pkg::item_t   hold_item;
  csvt_pkg::result_t result;
  logic              hold_valid;
  logic              out_ready;
  logic              advance;

  assign item_in.op        = op;
  assign item_in.text_byte = text_byte;
  assign advance           = hold_valid & out_ready;

  csvt_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .item_in    (item_in),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  csvt_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_item),
    .result (result)
  );

  csvt_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .result      (result),
    .ready       (out_ready),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .kind        (kind),
    .cell_byte   (cell_byte)
  );

endmodule

@@ src/csvt_in_reg.sv @@
// ----------------------------------------------------------------------------
// csvt_in_reg
// input register stage, holds one text transaction until the parser takes it
// ----------------------------------------------------------------------------
module csvt_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           text_valid,
  output logic           text_stall,
  input  csvt_pkg::item_t item_in,
  input  logic           advance,
  output logic           hold_valid,
  output csvt_pkg::item_t hold_item
);

  logic load;
  logic hold_valid_next;

  assign text_stall      = hold_valid & ~advance;
  assign load            = text_valid & ~text_stall;
  assign hold_valid_next = load | (hold_valid & ~advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_item <= item_in;
    end
  end

endmodule

@@ src/csvt_parse.sv @@
// ----------------------------------------------------------------------------
// csvt_parse
// quoting and cell state flags, decode of one item into at most one result
// ----------------------------------------------------------------------------
module csvt_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  csvt_pkg::item_t  item,
  output csvt_pkg::result_t result
);

  logic in_quotes, in_quotes_next;
  logic quote_pending, quote_pending_next;
  logic cell_nonempty, cell_nonempty_next;
  logic row_started, row_started_next;

  always_comb begin
    logic q;
    logic done;
    in_quotes_next     = in_quotes;
    quote_pending_next = quote_pending;
    cell_nonempty_next = cell_nonempty;
    row_started_next   = row_started;
    result.emit        = 1'b0;
    result.kind        = csvt_pkg::KIND_BYTE;
    result.cell_byte   = 8'd0;
    q                  = in_quotes;
    done               = 1'b0;
    if (item.op == csvt_pkg::OP_END) begin
      result.emit        = cell_nonempty | row_started;
      result.kind        = csvt_pkg::KIND_ROW;
      in_quotes_next     = 1'b0;
      quote_pending_next = 1'b0;
      cell_nonempty_next = 1'b0;
      row_started_next   = 1'b0;
    end else begin
      // pending quote resolved by this byte
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (item.text_byte == csvt_pkg::CH_QUOTE) begin
          cell_nonempty_next = 1'b1;
          result.emit        = 1'b1;
          result.cell_byte   = csvt_pkg::CH_QUOTE;
          done               = 1'b1;
        end else begin
          q              = 1'b0;
          in_quotes_next = 1'b0;
        end
      end
      if (!done) begin
        if (q) begin
          if (item.text_byte == csvt_pkg::CH_QUOTE) begin
            quote_pending_next = 1'b1;
          end else begin
            cell_nonempty_next = 1'b1;
            result.emit        = 1'b1;
            result.cell_byte   = item.text_byte;
          end
        end else begin
          case (item.text_byte)
            csvt_pkg::CH_QUOTE: begin
              in_quotes_next = 1'b1;
            end
            csvt_pkg::CH_COMMA: begin
              cell_nonempty_next = 1'b0;
              row_started_next   = 1'b1;
              result.emit        = 1'b1;
              result.kind        = csvt_pkg::KIND_CELL;
            end
            csvt_pkg::CH_CR: begin
            end
            csvt_pkg::CH_LF: begin
              cell_nonempty_next = 1'b0;
              row_started_next   = 1'b0;
              result.emit        = 1'b1;
              result.kind        = csvt_pkg::KIND_ROW;
            end
            default: begin
              cell_nonempty_next = 1'b1;
              result.emit        = 1'b1;
              result.cell_byte   = item.text_byte;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
      cell_nonempty <= 1'b0;
      row_started   <= 1'b0;
    end else if (step) begin
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
      cell_nonempty <= cell_nonempty_next;
      row_started   <= row_started_next;
    end
  end

`ifndef ASSERT_OFF
  a_pending_in_quotes: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> in_quotes)
    else $error("quote pending outside quoting");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.op == csvt_pkg::OP_END |=>
      !in_quotes && !quote_pending && !cell_nonempty && !row_started)
    else $error("state not cleared after end of text");

  a_byte_only_kind: assert property (@(posedge clk) disable iff (rst)
    result.emit && result.kind != csvt_pkg::KIND_BYTE |-> result.cell_byte == 8'd0)
    else $error("nonzero byte on cell or row end");
`endif

endmodule

@@ src/csvt_out_reg.sv @@
// ----------------------------------------------------------------------------
// csvt_out_reg
// result register on the token channel
// ----------------------------------------------------------------------------
module csvt_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  csvt_pkg::result_t result,
  output logic              ready,
  output logic              token_valid,
  input  logic              token_stall,
  output logic [1:0]        kind,
  output logic [7:0]        cell_byte
);

  logic token_valid_next;

  assign ready            = ~token_valid | ~token_stall;
  assign token_valid_next = (load & result.emit) | (token_valid & token_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else begin
      token_valid <= token_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && result.emit) begin
      kind      <= result.kind;
      cell_byte <= result.cell_byte;
    end
  end

endmodule
